/* design/sbld_pkg.sv */
// Shared types, constants and helpers of the start/BCD-length/XOR deframer.
// No dependencies; every other design file imports this package.
`default_nettype none

package sbld_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LEN_W         = 15;
   localparam int unsigned KEY_COUNT     = 5;
   localparam int unsigned KEY_REG_BYTES = 5;
   localparam int unsigned KEY_W         = KEY_REG_BYTES * BYTE_W;
   localparam int unsigned KEY_POS_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = KEY_W;
   localparam int unsigned LEN_MAX       = 16665;

   localparam logic [BYTE_W-1:0] START_BYTE    = 8'hF2;
   localparam logic [LEN_W-1:0]  DEFAULT_LIMIT = 15'd1024;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_MSB = 3'd1,
      PH_LEN_LSB = 3'd2,
      PH_DATA    = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_DATA     = 3'd0,
      EV_GOOD     = 3'd1,
      EV_BAD_SUM  = 3'd2,
      EV_TOO_LONG = 3'd3,
      EV_NO_START = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY        = 2'd0,
      CSR_DESCRAMBLE = 2'd1,
      CSR_LIMIT      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_bytes;
      logic             descramble_enable;
      logic [LEN_W-1:0] length_limit;
   } cfg_type;

   typedef struct packed {
      event_type         event_kind;
      logic [BYTE_W-1:0] raw_byte;
      logic [BYTE_W-1:0] plain_byte;
      logic              plain_valid;
      logic [LEN_W-1:0]  byte_count;
   } rsp_type;

   // Packed BCD byte to binary: x - hi_nibble*6, range 0..165.
   function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] x);
      logic [BYTE_W-1:0] hi;
      hi = {4'b0000, x[7:4]};
      return BYTE_W'(x - BYTE_W'(hi * 8'd6));
   endfunction

   // Key byte at a position; positions past the register read as zero.
   function automatic logic [BYTE_W-1:0] key_select(input logic [KEY_W-1:0]     key,
                                                     input logic [KEY_POS_W-1:0] pos);
      logic [BYTE_W-1:0] sel;
      sel = '0;
      for (int i = 0; i < KEY_REG_BYTES; i++) begin
         if (int'(pos) == i) begin
            sel = key[i*BYTE_W +: BYTE_W];
         end
      end
      return sel;
   endfunction

endpackage

`default_nettype wire

/* design/sbld_if.sv */
// Valid/ready channel interfaces for the deframer's byte input and event output.
// Depends on sbld_pkg.
`default_nettype none

interface sbld_req_if;
   import sbld_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbld_rsp_if;
   import sbld_pkg::*;

   logic              valid;
   logic              ready;
   logic [2:0]        event_kind;
   logic [BYTE_W-1:0] raw_byte;
   logic [BYTE_W-1:0] plain_byte;
   logic              plain_valid;
   logic [LEN_W-1:0]  byte_count;

   modport source (output valid, output event_kind, output raw_byte, output plain_byte,
                   output plain_valid, output byte_count, input ready);
   modport sink   (input valid, input event_kind, input raw_byte, input plain_byte,
                   input plain_valid, input byte_count, output ready);
endinterface

`default_nettype wire

/* design/sbld_csr.sv */
// Configuration registers of the deframer: key bytes, descramble enable, length limit.
// Depends on sbld_pkg.
`default_nettype none

module sbld_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [sbld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sbld_pkg::CSR_DATA_W-1:0] csr_wdata,
   output sbld_pkg::cfg_type                   cfg
);
   import sbld_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY:        cfg_in.key_bytes         = csr_wdata[KEY_W-1:0];
            CSR_DESCRAMBLE: cfg_in.descramble_enable = csr_wdata[0];
            CSR_LIMIT:      cfg_in.length_limit      = csr_wdata[LEN_W-1:0];
            default:        cfg_in = cfg_ff;   // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes         <= '0;
         cfg_ff.descramble_enable <= 1'b0;
         cfg_ff.length_limit      <= DEFAULT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/sbld_core.sv */
// Deframer datapath: input byte register, frame state machine, event result register.
// Depends on sbld_pkg and the channel interfaces in sbld_if.sv.
`default_nettype none

module sbld_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  sbld_pkg::cfg_type cfg,
   sbld_req_if.sink         req_ch,
   sbld_rsp_if.source       rsp_ch
);
   import sbld_pkg::*;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   remaining_ff, remaining_in;
   logic [LEN_W-1:0]   data_count_ff, data_count_in;
   logic [BYTE_W-1:0]  running_xor_ff, running_xor_in;
   logic [KEY_POS_W-1:0] key_pos_ff, key_pos_in;

   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;

   logic    out_free;
   logic    step;
   logic    req_take;
   logic    res_valid;
   rsp_type res;

   logic [BYTE_W-1:0] dec;
   logic [LEN_W-1:0]  len_sum;
   logic [LEN_W-1:0]  count_next;
   logic [LEN_W-1:0]  remain_next;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign step     = in_valid_ff && out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || out_free;

   always_comb begin
      dec         = bcd_decode(in_byte_ff);
      len_sum     = remaining_ff + LEN_W'(dec);
      count_next  = data_count_ff + LEN_W'(1);
      remain_next = (remaining_ff != '0) ? remaining_ff - LEN_W'(1) : '0;

      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      data_count_in  = data_count_ff;
      running_xor_in = running_xor_ff;
      key_pos_in     = key_pos_ff;

      res_valid       = 1'b0;
      res.event_kind  = EV_DATA;
      res.raw_byte    = in_byte_ff;
      res.plain_byte  = '0;
      res.plain_valid = 1'b0;
      res.byte_count  = '0;

      case (phase_ff)
         PH_LEN_MSB: begin
            remaining_in   = LEN_W'(dec) * LEN_W'(100);
            running_xor_in = in_byte_ff;
            phase_in       = PH_LEN_LSB;
         end
         PH_LEN_LSB: begin
            remaining_in = len_sum;
            if (len_sum > cfg.length_limit) begin
               res_valid      = 1'b1;
               res.event_kind = EV_TOO_LONG;
               res.byte_count = len_sum;
               phase_in       = PH_HUNT;
            end else begin
               running_xor_in = running_xor_ff ^ in_byte_ff;
               data_count_in  = '0;
               key_pos_in     = '0;
               phase_in       = (len_sum == '0) ? PH_CHECK : PH_DATA;
            end
         end
         PH_DATA: begin
            data_count_in   = count_next;
            remaining_in    = remain_next;
            running_xor_in  = running_xor_ff ^ in_byte_ff;
            res_valid       = 1'b1;
            res.event_kind  = EV_DATA;
            res.plain_byte  = in_byte_ff;
            res.plain_valid = 1'b1;
            res.byte_count  = data_count_ff;
            if (remain_next == '0) begin
               phase_in = PH_CHECK;
            end
            if (cfg.descramble_enable) begin
               // first and last data bytes stay in the clear
               if (count_next > LEN_W'(1) && remain_next != '0) begin
                  res.plain_byte = in_byte_ff ^ key_select(cfg.key_bytes, key_pos_ff);
                  key_pos_in     = (key_pos_ff == KEY_POS_W'(KEY_COUNT - 1)) ?
                                   '0 : key_pos_ff + KEY_POS_W'(1);
               end else begin
                  res.plain_valid = 1'b0;
               end
            end
         end
         PH_CHECK: begin
            res_valid      = 1'b1;
            res.event_kind = (in_byte_ff == running_xor_ff) ? EV_GOOD : EV_BAD_SUM;
            res.byte_count = data_count_ff;
            phase_in       = PH_HUNT;
         end
         default: begin
            if (in_byte_ff == START_BYTE) begin
               phase_in = PH_LEN_MSB;
            end else begin
               res_valid      = 1'b1;
               res.event_kind = EV_NO_START;
               phase_in       = PH_HUNT;
            end
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_HUNT;
         remaining_ff   <= '0;
         data_count_ff  <= '0;
         running_xor_ff <= '0;
         key_pos_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff       <= phase_in;
            remaining_ff   <= remaining_in;
            data_count_ff  <= data_count_in;
            running_xor_ff <= running_xor_in;
            key_pos_ff     <= key_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.event_kind  = out_ff.event_kind;
   assign rsp_ch.raw_byte    = out_ff.raw_byte;
   assign rsp_ch.plain_byte  = out_ff.plain_byte;
   assign rsp_ch.plain_valid = out_ff.plain_valid;
   assign rsp_ch.byte_count  = out_ff.byte_count;

   // a byte in the data phase always has at least one byte still owed
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != '0)
      else $error("data phase with nothing remaining");

   assert property (@(posedge clock) disable iff (reset)
      int'(key_pos_ff) < KEY_COUNT)
      else $error("key position out of range");

   // a held input byte is never dropped while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost under stall");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.plain_valid |-> out_ff.event_kind == EV_DATA)
      else $error("plain_valid on a non-data event");

   assert property (@(posedge clock) disable iff (reset)
      int'(remaining_ff) <= LEN_MAX)
      else $error("remaining count above largest BCD length");

endmodule

`default_nettype wire

/* design/stx_bcd_length_xor_deframer.sv */
// Top level of the start/BCD-length/XOR-checksum deframer.
// Depends on sbld_pkg, sbld_if.sv, sbld_csr and sbld_core.
//
// Feed received bytes on req_ch, one transaction per byte; events come out
// on rsp_ch. The block takes one byte per clock sustained while rsp_ch is
// not stalled: each byte is captured in an input register, runs through the
// frame state machine and, when it causes an event, lands in a result
// register that drives rsp_ch. Start, length and valid-length bytes give no
// event. While rsp_ch is stalled one more byte is held in the input register
// before req_ch.ready drops. There is no clearing pass after reset. Write
// csr_* only while no byte is in flight.
`default_nettype none

module stx_bcd_length_xor_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sbld_req_if.sink                            req_ch,
   sbld_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [sbld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sbld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sbld_pkg::*;

   cfg_type cfg;

   sbld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbld_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

/* dv/tb_stx_bcd_length_xor_deframer.sv */
// Testbench for stx_bcd_length_xor_deframer: streams received bytes through
// the deframer and checks every event against an in-bench frame tracker.
// Depends on sbld_pkg, sbld_if.sv and the deframer RTL.

module tb_stx_bcd_length_xor_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import sbld_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 250000;
   localparam int unsigned DRAIN_CYCLES  = 6;
   localparam int unsigned PHASE_BYTES   = 80;
   localparam int unsigned SETTING_COUNT = 8;
   // index past the register list; the block must ignore it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sbld_req_if req_ch();
   sbld_rsp_if rsp_ch();

   stx_bcd_length_xor_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // frame tracker state and its copy of the registers
   phase_type        trk_phase;
   logic [LEN_W-1:0] trk_left;
   logic [LEN_W-1:0] trk_count;
   logic [7:0]       trk_xor;
   int unsigned      trk_key_pos;
   logic [KEY_W-1:0] cfg_key;
   logic             cfg_descramble;
   logic [LEN_W-1:0] cfg_limit;

   rsp_type     expected_events[$];
   logic [7:0]  pending_bytes[$];
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned bytes_sent   = 0;
   int unsigned events_seen  = 0;
   int unsigned kind_seen[5] = '{default: 0};
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned mode_left    = 0;
   rx_pattern_type ready_mode = RX_OPEN;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned bcd_value(input logic [7:0] b);
      return int'(b) - int'(b[7:4]) * 6;
   endfunction

   function automatic logic [7:0] bcd_encode(input int unsigned n);
      return {4'(n / 10), 4'(n % 10)};
   endfunction

   // Advance the frame tracker by one byte; returns the event it causes, if any.
   function automatic void track_byte(input logic [7:0] b, output bit emits,
                                      output rsp_type ev);
      logic [7:0] key_byte;
      emits = 1'b0;
      ev = '0;
      ev.raw_byte = b;
      case (trk_phase)
         PH_LEN_MSB: begin
            trk_left  = LEN_W'(bcd_value(b) * 100);
            trk_xor   = b;
            trk_phase = PH_LEN_LSB;
         end
         PH_LEN_LSB: begin
            trk_left = LEN_W'(trk_left + bcd_value(b));
            if (trk_left > cfg_limit) begin
               emits = 1'b1;
               ev.event_kind = EV_TOO_LONG;
               ev.byte_count = trk_left;
               trk_phase = PH_HUNT;
            end else begin
               trk_xor     = trk_xor ^ b;
               trk_count   = '0;
               trk_key_pos = 0;
               trk_phase   = (trk_left == 0) ? PH_CHECK : PH_DATA;
            end
         end
         PH_DATA: begin
            emits = 1'b1;
            ev.event_kind  = EV_DATA;
            ev.byte_count  = trk_count;
            ev.plain_byte  = b;
            ev.plain_valid = 1'b1;
            trk_count = LEN_W'(trk_count + 1);
            if (trk_left != 0) trk_left = trk_left - 1'b1;
            trk_xor = trk_xor ^ b;
            if (trk_left == 0) trk_phase = PH_CHECK;
            if (cfg_descramble) begin
               // first and last data bytes pass in the clear, key holds still
               if (trk_count > 1 && trk_left != 0) begin
                  key_byte = (trk_key_pos < KEY_REG_BYTES) ?
                             cfg_key[8*trk_key_pos +: 8] : 8'h00;
                  ev.plain_byte = b ^ key_byte;
                  trk_key_pos = (trk_key_pos + 1) % KEY_COUNT;
               end else begin
                  ev.plain_valid = 1'b0;
               end
            end
         end
         PH_CHECK: begin
            emits = 1'b1;
            ev.event_kind = (b == trk_xor) ? EV_GOOD : EV_BAD_SUM;
            ev.byte_count = trk_count;
            trk_phase = PH_HUNT;
         end
         default: begin
            if (b == START_BYTE) begin
               trk_phase = PH_LEN_MSB;
            end else begin
               emits = 1'b1;
               ev.event_kind = EV_NO_START;
               trk_phase = PH_HUNT;
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Start byte, two length bytes, data and checksum. A cut frame stops after
   // a random share of its data and carries no checksum.
   function automatic void push_frame(input logic [7:0] msb, input logic [7:0] lsb,
                                      input int unsigned data_n, input bit bad_sum,
                                      input bit cut_short);
      logic [7:0]  sum;
      logic [7:0]  d;
      int unsigned n;
      sum = msb ^ lsb;
      n = cut_short ? $urandom_range(0, data_n) : data_n;
      pending_bytes.push_back(START_BYTE);
      pending_bytes.push_back(msb);
      pending_bytes.push_back(lsb);
      for (int i = 0; i < n; i++) begin
         d = 8'($urandom);
         sum = sum ^ d;
         pending_bytes.push_back(d);
      end
      if (!cut_short)
         pending_bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endfunction

   function automatic void push_random_traffic(input int unsigned budget,
                                               input int unsigned limit);
      int unsigned base;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  msb;
      logic [7:0]  lsb;
      base = pending_bytes.size();
      while (pending_bytes.size() - base < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 12);
            msb = 8'h00;
            lsb = bcd_encode(len);
            if (pick < 10) lsb = 8'($urandom);
            if (pick < 5)  msb = 8'($urandom);
            len = bcd_value(msb) * 100 + bcd_value(lsb);
            if (len > limit) begin
               push_frame(msb, lsb, 0, 1'b0, 1'b1);
            end else begin
               if (len > 170) begin
                  msb = 8'h00;
                  len = bcd_value(lsb);
               end
               push_frame(msb, lsb, len, $urandom_range(0, 6) == 0, 1'b0);
            end
         end else if (pick < 87) begin
            repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
         end else begin
            len = $urandom_range(2, 12);
            push_frame(8'h00, bcd_encode(len), len, 1'b0, 1'b1);
         end
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KEY:        cfg_key = value[KEY_W-1:0];
         CSR_DESCRAMBLE: cfg_descramble = value[0];
         CSR_LIMIT:      cfg_limit = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Sampled at the falling edge so the queues are settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left != 0 || pending_bytes.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (gap_left != 0) gap_left--;
         end else begin
            req_ch.valid   <= 1'b1;
            req_ch.rx_byte <= pending_bytes.pop_front();
            bytes_sent++;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // receiver: switches between stall patterns every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = rx_pattern_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_ch.ready <= (mode_left % 5 == 0);
            default:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // monitor: check the response transaction first, then track the request
   always @(posedge clock) begin
      rsp_type want;
      rsp_type ev;
      bit      emits;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            events_seen++;
            if (rsp_ch.event_kind < 5) kind_seen[rsp_ch.event_kind]++;
            if (expected_events.size() == 0) begin
               $display("%0t unexpected event: expected none, actual kind %0h raw %0h count %0h",
                        $time, rsp_ch.event_kind, rsp_ch.raw_byte, rsp_ch.byte_count);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_kind", want.event_kind, rsp_ch.event_kind);
               check_field("raw_byte", want.raw_byte, rsp_ch.raw_byte);
               check_field("plain_byte", want.plain_byte, rsp_ch.plain_byte);
               check_field("plain_valid", want.plain_valid, rsp_ch.plain_valid);
               check_field("byte_count", want.byte_count, rsp_ch.byte_count);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            track_byte(req_ch.rx_byte, emits, ev);
            if (emits) expected_events.push_back(ev);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d events outstanding",
                  $time, cycle_count, expected_events.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] limit;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_KEY;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      trk_phase      = PH_HUNT;
      trk_left       = '0;
      trk_count      = '0;
      trk_xor        = '0;
      trk_key_pos    = 0;
      cfg_key        = '0;
      cfg_descramble = 1'b0;
      cfg_limit      = DEFAULT_LIMIT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stray bytes, empty frame, longest length, bad checksum
      @(negedge clock);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      push_frame(8'h00, 8'h00, 0, 1'b0, 1'b0);
      push_frame(8'hFF, 8'hFF, 0, 1'b0, 1'b1);
      push_frame(8'h00, 8'h02, 2, 1'b1, 1'b0);
      wait_drained();

      // keyed, tight limit: length one over the limit, then one at it
      write_reg(CSR_KEY, 40'hA5_3C_96_0F_E1);
      write_reg(CSR_DESCRAMBLE, CSR_DATA_W'(1));
      write_reg(CSR_LIMIT, CSR_DATA_W'(3));
      write_reg(CSR_SPARE, '1);
      @(negedge clock);
      push_frame(8'h00, 8'h04, 0, 1'b0, 1'b1);
      push_frame(8'h00, 8'h03, 3, 1'b0, 1'b0);
      wait_drained();

      for (int s = 0; s < SETTING_COUNT; s++) begin
         case (s)
            0:       key = '0;
            1:       key = '1;
            default: key = {8'($urandom), 32'($urandom)};
         endcase
         case (s)
            0:       limit = '0;
            1:       limit = LEN_W'(LEN_MAX);
            2:       limit = DEFAULT_LIMIT;
            3:       limit = LEN_W'($urandom_range(1, 20));
            4:       limit = LEN_W'($urandom_range(0, LEN_MAX));
            default: limit = LEN_W'($urandom_range(5, 200));
         endcase
         write_reg(CSR_KEY, key);
         write_reg(CSR_DESCRAMBLE, CSR_DATA_W'(s % 3 != 0));
         write_reg(CSR_LIMIT, CSR_DATA_W'(limit));
         @(negedge clock);
         push_random_traffic(PHASE_BYTES, limit);
         wait_drained();
      end

      $display("run: %0d bytes over %0d register settings, %0d events checked",
               bytes_sent, SETTING_COUNT + 2, events_seen);
      $display("events: %0d data, %0d good, %0d bad sum, %0d too long, %0d no start",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
design/sbld_pkg.sv
design/sbld_if.sv
design/sbld_csr.sv
design/sbld_core.sv
design/stx_bcd_length_xor_deframer.sv
dv/tb_stx_bcd_length_xor_deframer.sv
